// ===== sv/cic_decimator_assert.svh =====
// Assertion macros used by the decimator RTL.
`ifndef CIC_DECIMATOR_ASSERT_SVH
`define CIC_DECIMATOR_ASSERT_SVH

// Condition must never hold at a clock edge outside reset.
`define CIC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

// Antecedent at an edge requires the consequent at the same edge.
`define CIC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== sv/cic_pkg.sv =====
// Shared types and constants of the CIC decimator.
`timescale 1ns / 1ps
package cic_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned SHIFT_W  = 5;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd10;

  // Queue slots beyond the integrator pipeline depth.
  localparam int unsigned QUEUE_SLACK = 4;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 32'sd32767;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -32'sd32768;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

// ===== sv/cic_decimator.sv =====
// An accepted sample whose phase emits passes through ORDER integrator stages, the queue,
// ORDER comb stages, the scaling register and the output register.
// Throughput: one sample per cycle; the integrator chain adds one stage per cycle and input
// ready drops only while the queue of ORDER+4 decimated sums holds 4 or more from a stalled output.
// Reset (async, active low): integrators, comb delays and queue cleared, phase loaded with
// DECIMATION, shift_q set to 10.
`timescale 1ns / 1ps
`include "cic_decimator_assert.svh"
module cic_decimator #(
  parameter int unsigned ORDER      = 4,
  parameter int unsigned DECIMATION = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [cic_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cic_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                                cfg_we_i,
  input  logic        [cic_pkg::SHIFT_W-1:0]  cfg_wdata_i
);
  import cic_pkg::*;

  localparam int unsigned DEPTH = ORDER + QUEUE_SLACK;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Room for every sum still in the integrator pipeline plus the new one.
  localparam logic [CNT_W-1:0] READY_LIMIT = CNT_W'(DEPTH - ORDER);

  logic [SHIFT_W-1:0] shift_q;
  logic               accept;
  logic               push;
  logic [ACC_W-1:0]   push_data;
  logic               pop;
  logic [ACC_W-1:0]   head;
  logic [CNT_W-1:0]   count;
  fifo_status_t       status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (count < READY_LIMIT);
  assign accept     = in_valid_i && in_ready_o;

  cic_front #(
    .ORDER      (ORDER),
    .DECIMATION (DECIMATION)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .sample_i    (sample_in_i),
    .push_o      (push),
    .push_data_o (push_data)
  );

  cic_fifo #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .count_o     (count),
    .status_o    (status)
  );

  cic_back #(
    .ORDER (ORDER)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (status),
    .shift_i     (shift_q),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_out_o)
  );

  `CIC_ASSERT_NEVER(a_no_push_full, push && status.full && !pop, "queue overflow")
  `CIC_ASSERT_NEVER(a_no_pop_empty, pop && status.empty, "queue underflow")
  `CIC_ASSERT_IMPLIES(a_stall_no_pop, out_valid_o && !out_ready_i, !pop, "pop while stalled")

endmodule

// ===== sv/cic_front.sv =====
// Integrator pipeline and decimation phase counter.
`timescale 1ns / 1ps
module cic_front #(
  parameter int unsigned ORDER      = 4,
  parameter int unsigned DECIMATION = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [cic_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                push_o,
  output logic        [cic_pkg::ACC_W-1:0]    push_data_o
);
  import cic_pkg::*;

  localparam int unsigned PHASE_W = $clog2(DECIMATION + 1);
  localparam logic [PHASE_W-1:0] PHASE_LOAD = PHASE_W'(DECIMATION);
  localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1);

  logic [ACC_W-1:0]   sum_q [ORDER];
  logic [ORDER-1:0]   vld_q;
  logic [ORDER-1:0]   dec_q;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               dec_now;
  logic [ACC_W-1:0]   sample_ext;

  assign sample_ext = {{(ACC_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  // A count of zero behaves like one: emit and reload.
  assign dec_now    = (phase_q <= PHASE_ONE);

  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      phase_d = dec_now ? PHASE_LOAD : phase_q - PHASE_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_LOAD;
      vld_q   <= '0;
      dec_q   <= '0;
      for (int i = 0; i < ORDER; i++) begin
        sum_q[i] <= '0;
      end
    end else begin
      phase_q  <= phase_d;
      vld_q[0] <= accept_i;
      dec_q[0] <= accept_i && dec_now;
      if (accept_i) begin
        sum_q[0] <= sum_q[0] + sample_ext;
      end
      // Each stage adds the freshly updated sum of the stage before it.
      for (int i = 1; i < ORDER; i++) begin
        vld_q[i] <= vld_q[i-1];
        dec_q[i] <= dec_q[i-1];
        if (vld_q[i-1]) begin
          sum_q[i] <= sum_q[i] + sum_q[i-1];
        end
      end
    end
  end

  assign push_o      = vld_q[ORDER-1] && dec_q[ORDER-1];
  assign push_data_o = sum_q[ORDER-1];

endmodule

// ===== sv/cic_fifo.sv =====
// Queue of decimated integrator sums between front and back.
`timescale 1ns / 1ps
module cic_fifo #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned CNT_W = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [cic_pkg::ACC_W-1:0]    push_data_i,
  input  logic                         pop_i,
  output logic [cic_pkg::ACC_W-1:0]    head_o,
  output logic [CNT_W-1:0]             count_o,
  output cic_pkg::fifo_status_t        status_o
);
  import cic_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [ACC_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_ONE;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_ONE;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_ONE;
        2'b01:   cnt_q <= cnt_q - CNT_ONE;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o         = mem_q[rd_q];
  assign count_o        = cnt_q;
  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CNT_FULL);

endmodule

// ===== sv/cic_back.sv =====
// Comb pipeline, scaling toward zero, saturation and output register.
`timescale 1ns / 1ps
module cic_back #(
  parameter int unsigned ORDER = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic        [cic_pkg::ACC_W-1:0]    head_i,
  input  cic_pkg::fifo_status_t               status_i,
  input  logic        [cic_pkg::SHIFT_W-1:0]  shift_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cic_pkg::SAMPLE_W-1:0] sample_o
);
  import cic_pkg::*;

  logic [ACC_W-1:0]          c_q   [ORDER];
  logic [ACC_W-1:0]          dly_q [ORDER];
  logic [ACC_W-1:0]          cin   [ORDER];
  logic [ORDER-1:0]          cv_q;
  logic [ORDER-1:0]          cin_v;
  logic                      en;
  logic                      sv_q;
  logic signed [ACC_W-1:0]   sc_q;
  logic signed [ACC_W-1:0]   comb_out;
  logic        [ACC_W-1:0]   bias;
  logic signed [ACC_W:0]     biased;
  logic signed [ACC_W:0]     shifted;
  logic                      ov_q;
  logic signed [SAMPLE_W-1:0] od_q;
  logic signed [SAMPLE_W-1:0] sat;

  // Advance the whole back pipeline only when the output slot frees up.
  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && !status_i.empty;

  always_comb begin
    cin[0]   = head_i;
    cin_v[0] = !status_i.empty;
    for (int s = 1; s < ORDER; s++) begin
      cin[s]   = c_q[s-1];
      cin_v[s] = cv_q[s-1];
    end
  end

  // Negative values get 2^shift-1 added so the arithmetic shift truncates toward zero.
  assign comb_out = $signed(c_q[ORDER-1]);
  assign bias     = comb_out[ACC_W-1] ? ((ACC_W'(1) << shift_i) - ACC_W'(1)) : '0;
  assign biased   = $signed({comb_out[ACC_W-1], comb_out}) + $signed({1'b0, bias});
  assign shifted  = biased >>> shift_i;

  always_comb begin
    if (sc_q > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_W-1:0];
    end else if (sc_q < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat = sc_q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
      sv_q <= 1'b0;
      ov_q <= 1'b0;
      for (int s = 0; s < ORDER; s++) begin
        dly_q[s] <= '0;
      end
    end else if (en) begin
      cv_q <= cin_v;
      sv_q <= cv_q[ORDER-1];
      ov_q <= sv_q;
      for (int s = 0; s < ORDER; s++) begin
        if (cin_v[s]) begin
          dly_q[s] <= cin[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < ORDER; s++) begin
        if (cin_v[s]) begin
          c_q[s] <= cin[s] - dly_q[s];
        end
      end
      sc_q <= shifted[ACC_W-1:0];
      od_q <= sat;
    end
  end

  assign out_valid_o = ov_q;
  assign sample_o    = od_q;

endmodule

// ===== tb/cic_decimator_checker.sv =====
// Scoreboard for the CIC decimator: tracks the filter state and checks every output sample.
`timescale 1ns / 1ps
module cic_decimator_checker #(
  parameter int unsigned ORDER      = 4,
  parameter int unsigned DECIMATION = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [cic_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [cic_pkg::SAMPLE_W-1:0] sample_out_i,
  input  logic                                cfg_we_i,
  input  logic        [cic_pkg::SHIFT_W-1:0]  cfg_wdata_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  import cic_pkg::*;

  logic [ACC_W-1:0]          integ_sum [ORDER];
  logic [ACC_W-1:0]          comb_prev [ORDER];
  int unsigned               phase_left;
  logic [SHIFT_W-1:0]        atten_shift;
  logic signed [SAMPLE_W-1:0] decimated_q [$];
  int unsigned               fails = 0;

  // Divide by 2^sh truncating toward zero, then clip to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] scale_and_clip(
    input logic [ACC_W-1:0]   comb_out,
    input logic [SHIFT_W-1:0] sh
  );
    longint wide;
    longint quot;
    wide = longint'(signed'(comb_out));
    if (wide < 0) quot = -((-wide) >> sh);
    else          quot = wide >> sh;
    if (quot > longint'(SAT_MAX)) quot = longint'(SAT_MAX);
    if (quot < longint'(SAT_MIN)) quot = longint'(SAT_MIN);
    return quot[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [ACC_W-1:0]           stage;
    logic [ACC_W-1:0]           held;
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        integ_sum[i] = '0;
        comb_prev[i] = '0;
      end
      phase_left  = DECIMATION;
      atten_shift = SHIFT_RESET;
      decimated_q.delete();
    end else begin
      if (cfg_we_i) atten_shift = cfg_wdata_i;

      // Check the output first: a sample accepted now cannot leave in the same cycle.
      if (out_valid_i && out_ready_i) begin
        if (decimated_q.size() == 0) begin
          $error("sample_out: unexpected transfer, actual %0d", sample_out_i);
          fails++;
        end else begin
          want = decimated_q.pop_front();
          if (sample_out_i !== want) begin
            $error("sample_out mismatch: expected %0d, actual %0d", want, sample_out_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        stage = {{(ACC_W-SAMPLE_W){sample_in_i[SAMPLE_W-1]}}, sample_in_i};
        for (int i = 0; i < ORDER; i++) begin
          integ_sum[i] = integ_sum[i] + stage;
          stage        = integ_sum[i];
        end
        if (phase_left > 1) begin
          phase_left--;
        end else begin
          phase_left = DECIMATION;
          for (int i = 0; i < ORDER; i++) begin
            held         = stage;
            stage        = stage - comb_prev[i];
            comb_prev[i] = held;
          end
          decimated_q = {decimated_q, scale_and_clip(stage, atten_shift)};
        end
      end
    end
    pending_o    <= decimated_q.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/tb_cic_decimator.sv =====
// Testbench top for the CIC decimator: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps
module tb_cic_decimator;
  import cic_pkg::*;

  localparam int unsigned ORDER       = 4;
  localparam int unsigned DECIMATION  = 5;
  localparam int unsigned LATENCY     = 2 * ORDER + 2;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       cfg_we    = 1'b0;
  logic        [SHIFT_W-1:0]  cfg_wdata = '0;
  int unsigned                fail_count;
  int unsigned                pending;
  int unsigned                cycles    = 0;
  int unsigned                stall_left = 0;
  int unsigned                stall_mode = 0;

  always #10 clk = ~clk;

  cic_decimator #(
    .ORDER      (ORDER),
    .DECIMATION (DECIMATION)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_o (sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  cic_decimator_checker #(
    .ORDER      (ORDER),
    .DECIMATION (DECIMATION)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_in_i  (sample_in),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .sample_out_i (sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stalls: switch between always ready, coin flip and mostly stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Hold valid and payload until the transfer; leave valid high for a following item.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    in_valid  <= 1'b1;
    sample_in <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_for(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_shift(input logic [SHIFT_W-1:0] value);
    drain();
    // Let the tail of the pipeline empty out before touching the register.
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_stream(input int unsigned count);
    int unsigned                left;
    int unsigned                burst;
    int unsigned                style;
    logic signed [SAMPLE_W-1:0] level;
    left = count;
    while (left > 0) begin
      style = $urandom_range(0, 3);
      burst = (style == 1) ? $urandom_range(20, 60) : $urandom_range(1, 24);
      level = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (burst > left) burst = left;
      repeat (burst) begin
        case (style)
          0: send_sample(16'($urandom));
          1: send_sample(level);
          2: send_sample(16'($urandom_range(0, 127)) - 16'd64);
          default: begin
            send_sample(level);
            level = ~level;
          end
        endcase
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end
  endtask

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] corner [20];
    logic [SHIFT_W-1:0]         shift_val;
    corner = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
               16'sh0000, 16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa,
               16'sh7fff, 16'sh8000, 16'sh0100, 16'shff00, 16'sh0000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at the reset shift.
    foreach (corner[i]) send_sample(corner[i]);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: shift_val = '0;
        1: shift_val = '1;
        2: shift_val = 5'd9;
        3: shift_val = SHIFT_RESET;
        default: shift_val = SHIFT_W'($urandom_range(0, 31));
      endcase
      write_shift(shift_val);
      run_stream(PHASE_ITEMS / 2);
      drain();
      run_stream(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    drain();
    repeat (3 * LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
